FILE: design/mandel_pkg.sv
// Shared constants, types and the saturating helper function of the escape-time evaluator.
package mandel_pkg;

  localparam int FRAC_BITS  = 26;
  localparam int INDEX_BITS = 24;
  localparam int COUNT_BITS = 16;

  localparam int WORD_BITS      = 32;
  localparam int WIDTH_BITS     = 13;
  localparam int LIMIT_BITS     = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int MUL_A_BITS     = WORD_BITS + 1;
  localparam int PROD_BITS      = MUL_A_BITS + WORD_BITS;
  localparam int WIDE_BITS      = PROD_BITS + 1;
  localparam int SQ_BITS        = 2 * WORD_BITS - 1;
  localparam int DIV_CNT_BITS   = $clog2(INDEX_BITS);

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ITERATION_LIMIT = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_REAL     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_IMAG     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PIXEL_STEP      = 3'd4;

  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(640);
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(256);
  localparam logic signed [WORD_BITS-1:0] STEP_RESET = WORD_BITS'(1) << FRAC_BITS;

  localparam logic [SQ_BITS:0] ESC_LIMIT = (SQ_BITS + 1)'(4) << (2 * FRAC_BITS);

  localparam logic signed [WIDE_BITS-1:0] WORD_MAX =
    {{(WIDE_BITS - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
  localparam logic signed [WIDE_BITS-1:0] WORD_MIN =
    {{(WIDE_BITS - WORD_BITS + 1){1'b1}}, {(WORD_BITS - 1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_CRE,
    S_CIM,
    S_CI,
    S_UPD,
    S_RR,
    S_II,
    S_CHK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                  start;
    logic [INDEX_BITS-1:0] dividend;
    logic [WIDTH_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [INDEX_BITS-1:0] quotient;
    logic [WIDTH_BITS-1:0] remainder;
  } div_res_t;

  typedef struct packed {
    logic                        hit;
    logic signed [WORD_BITS-1:0] value;
  } sat_t;

  function automatic sat_t sat_word(input logic signed [WIDE_BITS-1:0] v);
    sat_t r;
    r.hit = 1'b1;
    if (v > WORD_MAX) begin
      r.value = WORD_MAX[WORD_BITS-1:0];
    end else if (v < WORD_MIN) begin
      r.value = WORD_MIN[WORD_BITS-1:0];
    end else begin
      r.hit   = 1'b0;
      r.value = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/mandel_div.sv
// Restoring divider that splits a pixel index into row and column, one bit a cycle.
module mandel_div
  import mandel_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_res_t res_o
);

  localparam logic [DIV_CNT_BITS-1:0] CNT_MAX = DIV_CNT_BITS'(INDEX_BITS - 1);

  logic                    busy_q;
  logic                    done_q;
  logic [DIV_CNT_BITS-1:0] cnt_q;
  logic [INDEX_BITS-1:0]   quot_q;
  logic [WIDTH_BITS-1:0]   rem_q;
  logic [WIDTH_BITS-1:0]   divisor_q;

  logic [WIDTH_BITS:0]   trial;
  logic [WIDTH_BITS:0]   diff;
  logic                  fits;
  logic [WIDTH_BITS-1:0] rem_d;

  always_comb begin
    trial = {rem_q, quot_q[INDEX_BITS-1]};
    diff  = trial - {1'b0, divisor_q};
    fits  = trial >= {1'b0, divisor_q};
    rem_d = fits ? diff[WIDTH_BITS-1:0] : trial[WIDTH_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_MAX;
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q    <= req_i.dividend;
      rem_q     <= '0;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      quot_q <= {quot_q[INDEX_BITS-2:0], fits};
      rem_q  <= rem_d;
    end
  end

  assign res_o.done      = done_q;
  assign res_o.quotient  = quot_q;
  assign res_o.remainder = rem_q;

endmodule

FILE: design/mandelbrot_escape_time.sv
// Top level of the escape-time evaluator: sequencer, shared multiplier and registers.
// A request is split into row and column by the divider, then c is formed and z is updated until
// it escapes or the limit is reached; the iteration count is the number of z updates done, less one when z escapes.
// One request is taken at a time, only in the idle state; the single shared multiplier serves
// every product of a z update in turn, and the next request waits until the result is loaded.
// Reset clears the sequencer and output valid and loads the register defaults.
module mandelbrot_escape_time
  import mandel_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [WORD_BITS-1:0]      cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [INDEX_BITS-1:0]     pixel_index_i,
  input  logic                      last_pixel_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [COUNT_BITS-1:0]     iteration_count_o,
  output logic                      last_pixel_out_o
);

  state_e state_q, state_d;

  logic [WIDTH_BITS-1:0]       width_q;
  logic [LIMIT_BITS-1:0]       limit_q;
  logic signed [WORD_BITS-1:0] origin_re_q;
  logic signed [WORD_BITS-1:0] origin_im_q;
  logic signed [WORD_BITS-1:0] step_q;

  logic signed [WORD_BITS-1:0] cr_q, ci_q, zr_q, zi_q;
  logic [SQ_BITS-1:0]          rr_q, ii_q;
  logic signed [PROD_BITS-1:0] prod_q;
  logic                        sat_q;
  logic [COUNT_BITS-1:0]       iter_q;
  logic                        last_q;
  logic                        out_valid_q;
  logic [COUNT_BITS-1:0]       count_q;
  logic                        last_out_q;

  logic [WIDTH_BITS-1:0] width_eff;
  div_req_t              div_req;
  div_res_t              div_res;

  logic signed [MUL_A_BITS-1:0] mul_a;
  logic signed [WORD_BITS-1:0]  mul_b;
  logic signed [PROD_BITS-1:0]  prod_d;
  logic                         load;
  logic                         in_ready;

  logic signed [WIDE_BITS-1:0] c_sum_re, c_sum_im;
  logic signed [WIDE_BITS-1:0] diff_sq, nr_sum, ni_sum;
  sat_t                        c_re, c_im, nr, ni;
  logic [SQ_BITS:0]            mag;
  logic                        escape;
  logic                        at_limit;

  assign width_eff = (width_q == '0) ? WIDTH_BITS'(1) : width_q;

  assign div_req.start    = in_valid_i && in_ready;
  assign div_req.dividend = pixel_index_i;
  assign div_req.divisor  = width_eff;

  mandel_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WIDTH_RESET;
      limit_q     <= LIMIT_RESET;
      origin_re_q <= '0;
      origin_im_q <= '0;
      step_q      <= STEP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:     width_q     <= cfg_data_i[WIDTH_BITS-1:0];
        REG_ITERATION_LIMIT: limit_q     <= cfg_data_i[LIMIT_BITS-1:0];
        REG_ORIGIN_REAL:     origin_re_q <= cfg_data_i;
        REG_ORIGIN_IMAG:     origin_im_q <= cfg_data_i;
        REG_PIXEL_STEP:      step_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    c_sum_re = $signed({{(WIDE_BITS - WORD_BITS){origin_re_q[WORD_BITS-1]}}, origin_re_q})
             + $signed({prod_q[PROD_BITS-1], prod_q});
    c_sum_im = $signed({{(WIDE_BITS - WORD_BITS){origin_im_q[WORD_BITS-1]}}, origin_im_q})
             + $signed({prod_q[PROD_BITS-1], prod_q});
    c_re     = sat_word(c_sum_re);
    c_im     = sat_word(c_sum_im);
    diff_sq  = $signed({{(WIDE_BITS - SQ_BITS){1'b0}}, rr_q})
             - $signed({{(WIDE_BITS - SQ_BITS){1'b0}}, ii_q});
    nr_sum   = (diff_sq >>> FRAC_BITS)
             + $signed({{(WIDE_BITS - WORD_BITS){cr_q[WORD_BITS-1]}}, cr_q});
    ni_sum   = ($signed({prod_q[PROD_BITS-1], prod_q}) >>> (FRAC_BITS - 1))
             + $signed({{(WIDE_BITS - WORD_BITS){ci_q[WORD_BITS-1]}}, ci_q});
    nr       = sat_word(nr_sum);
    ni       = sat_word(ni_sum);
    mag      = {1'b0, rr_q} + {1'b0, prod_q[SQ_BITS-1:0]};
    escape   = sat_q || (mag >= ESC_LIMIT);
    at_limit = (COUNT_BITS'(iter_q + 1'b1) == COUNT_BITS'(limit_q));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_DIV;
      S_DIV:  if (div_res.done) state_d = S_CRE;
      S_CRE:  state_d = S_CIM;
      S_CIM:  state_d = S_CI;
      S_CI:   state_d = (limit_q == '0) ? S_DONE : S_UPD;
      S_UPD:  state_d = S_RR;
      S_RR:   state_d = S_II;
      S_II:   state_d = S_CHK;
      S_CHK:  state_d = (escape || at_limit) ? S_DONE : S_UPD;
      S_DONE: if (load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    load     = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    case (state_q)
      S_IDLE: in_ready = 1'b1;
      S_CRE: begin
        mul_a = $signed({{(MUL_A_BITS - WIDTH_BITS){1'b0}}, div_res.remainder});
        mul_b = step_q;
      end
      S_CIM: begin
        mul_a = $signed({{(MUL_A_BITS - INDEX_BITS){1'b0}}, div_res.quotient});
        mul_b = step_q;
      end
      S_CI, S_CHK: begin
        mul_a = $signed({zr_q[WORD_BITS-1], zr_q});
        mul_b = zi_q;
      end
      S_RR: begin
        mul_a = $signed({zr_q[WORD_BITS-1], zr_q});
        mul_b = zr_q;
      end
      S_II: begin
        mul_a = $signed({zi_q[WORD_BITS-1], zi_q});
        mul_b = zi_q;
      end
      S_DONE: load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (div_req.start) begin
      last_q <= last_pixel_i;
    end
    if (load) begin
      count_q    <= iter_q;
      last_out_q <= last_q;
    end
    case (state_q)
      S_CRE: begin
        zr_q <= '0;
        zi_q <= '0;
        rr_q <= '0;
        ii_q <= '0;
      end
      S_CIM: cr_q <= c_re.value;
      S_CI: begin
        ci_q   <= c_im.value;
        iter_q <= '0;
      end
      S_UPD: begin
        zr_q  <= nr.value;
        zi_q  <= ni.value;
        sat_q <= nr.hit || ni.hit;
      end
      S_II: rr_q <= prod_q[SQ_BITS-1:0];
      S_CHK: begin
        ii_q <= prod_q[SQ_BITS-1:0];
        if (!escape) begin
          iter_q <= COUNT_BITS'(iter_q + 1'b1);
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o        = in_ready;
  assign out_valid_o       = out_valid_q;
  assign iteration_count_o = count_q;
  assign last_pixel_out_o  = last_out_q;

  a_count_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (iter_q <= COUNT_BITS'(limit_q)))
    else $error("Iteration count exceeds the limit.");

  a_col_in_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (div_res.remainder < width_eff))
    else $error("Column is not below the image width.");

  a_sat_escapes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK && sat_q) |=> (state_q == S_DONE))
    else $error("A saturated update did not end the pixel.");

endmodule

FILE: tb/sv/mandelbrot_escape_time_tb.sv
// Self-checking testbench for the Mandelbrot escape-time evaluator with a scoreboard class.
`timescale 1ns / 100ps

module mandelbrot_escape_time_tb;
  import mandel_pkg::*;

  localparam int     CLK_HALF     = 4;
  localparam int     RANDOM_ITEMS = 950;
  localparam int     ONE          = 1 << FRAC_BITS;
  localparam longint WORD_TOP     = 64'sd2147483647;
  localparam longint WORD_BOTTOM  = -64'sd2147483648;

  typedef struct {
    logic [COUNT_BITS-1:0] count;
    logic                  last_flag;
  } escape_result_t;

  class EscapeScoreboard;
    logic [WIDTH_BITS-1:0]       image_width;
    logic [LIMIT_BITS-1:0]       iter_limit;
    logic signed [WORD_BITS-1:0] re_origin;
    logic signed [WORD_BITS-1:0] im_origin;
    logic signed [WORD_BITS-1:0] step;
    escape_result_t              expected_q[$];
    int                          mismatches;

    function new();
      image_width = WIDTH_RESET;
      iter_limit  = LIMIT_RESET;
      re_origin   = '0;
      im_origin   = '0;
      step        = STEP_RESET;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [WORD_BITS-1:0] value);
      case (idx)
        REG_IMAGE_WIDTH:     image_width = value[WIDTH_BITS-1:0];
        REG_ITERATION_LIMIT: iter_limit = value[LIMIT_BITS-1:0];
        REG_ORIGIN_REAL:     re_origin = value;
        REG_ORIGIN_IMAG:     im_origin = value;
        REG_PIXEL_STEP:      step = value;
        default: ;
      endcase
    endfunction

    function longint clamp_word(longint v, inout bit hit);
      if (v > WORD_TOP) begin
        hit = 1'b1;
        return WORD_TOP;
      end
      if (v < WORD_BOTTOM) begin
        hit = 1'b1;
        return WORD_BOTTOM;
      end
      return v;
    endfunction

    // The shifts by the fraction width floor towards minus infinity, as the datapath does.
    function logic [COUNT_BITS-1:0] escape_count(logic [INDEX_BITS-1:0] pixel);
      longint            ix;
      longint            w;
      longint            cr;
      longint            ci;
      longint            zr;
      longint            zi;
      longint            nr;
      longint            ni;
      longint unsigned   mag;
      int unsigned       n;
      bit                hit;
      ix  = pixel;
      w   = (image_width == 0) ? 1 : image_width;
      hit = 1'b0;
      cr  = clamp_word(longint'(re_origin) + (ix % w) * longint'(step), hit);
      ci  = clamp_word(longint'(im_origin) + (ix / w) * longint'(step), hit);
      zr  = 0;
      zi  = 0;
      for (n = 0; n < iter_limit; n++) begin
        hit = 1'b0;
        nr  = clamp_word(((zr * zr - zi * zi) >>> FRAC_BITS) + cr, hit);
        ni  = clamp_word(((zr * zi) >>> (FRAC_BITS - 1)) + ci, hit);
        zr  = nr;
        zi  = ni;
        mag = zr * zr;
        mag = mag + zi * zi;
        if (hit || mag >= ESC_LIMIT) break;
      end
      return n[COUNT_BITS-1:0];
    endfunction

    task note_request(logic [INDEX_BITS-1:0] pixel, logic last_flag);
      escape_result_t r;
      r.count     = escape_count(pixel);
      r.last_flag = last_flag;
      expected_q.push_back(r);
    endtask

    task report(string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [COUNT_BITS-1:0] count, logic last_flag);
      escape_result_t r;
      if (expected_q.size() == 0) begin
        report($sformatf("result with no request pending: count %0d", count));
        return;
      end
      r = expected_q.pop_front();
      if (count !== r.count)
        report($sformatf("iteration count %0d, expected %0d", count, r.count));
      if (last_flag !== r.last_flag)
        report($sformatf("last pixel flag %b, expected %b", last_flag, r.last_flag));
    endtask
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_INDEX_BITS-1:0] cfg_index_i;
  logic [WORD_BITS-1:0]      cfg_data_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [INDEX_BITS-1:0]     pixel_index_i;
  logic                      last_pixel_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [COUNT_BITS-1:0]     iteration_count_o;
  logic                      last_pixel_out_o;

  EscapeScoreboard board;
  bit              calm;

  mandelbrot_escape_time dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .pixel_index_i     (pixel_index_i),
    .last_pixel_i      (last_pixel_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .iteration_count_o (iteration_count_o),
    .last_pixel_out_o  (last_pixel_out_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 38);
  endfunction

  task automatic send_pixel(logic [INDEX_BITS-1:0] pixel, logic last_flag);
    @(negedge clk_i);
    while (take_break()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_index_i <= pixel;
    last_pixel_i  <= last_flag;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(pixel, last_flag);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [WORD_BITS-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    board.set_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(logic [WORD_BITS-1:0] w, logic [WORD_BITS-1:0] lim,
                           logic [WORD_BITS-1:0] re, logic [WORD_BITS-1:0] im,
                           logic [WORD_BITS-1:0] st);
    drain();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_ITERATION_LIMIT, lim);
    write_reg(REG_ORIGIN_REAL, re);
    write_reg(REG_ORIGIN_IMAG, im);
    write_reg(REG_PIXEL_STEP, st);
  endtask

  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      out_ready_i <= !take_break();
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        board.check_result(iteration_count_o, last_pixel_out_o);
    end
  end

  initial begin
    #120_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int                    sent;
    int                    phase;
    int                    mode;
    int                    w;
    int                    lim;
    int                    re;
    int                    im;
    int                    st;
    int                    count;
    int                    k;
    longint                span;
    logic [INDEX_BITS-1:0] pix;
    logic                  last_flag;
    escape_result_t        r;

    board         = new();
    calm          = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_IMAGE_WIDTH;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    pixel_index_i = '0;
    last_pixel_i  = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: raw pixel coordinates, so the origin stays in the set.
    send_pixel(24'd0, 1'b0);
    send_pixel(24'd1, 1'b0);
    send_pixel(24'd2, 1'b0);
    send_pixel(24'd640, 1'b0);
    send_pixel(24'd641, 1'b0);
    send_pixel(24'hFFFFFF, 1'b1);

    // A width of zero behaves as one; a limit of zero gives no updates.
    configure(0, 0, 0, 0, ONE);
    send_pixel(24'd0, 1'b1);
    send_pixel(24'hABCDEF, 1'b0);
    configure(0, 20, 0, 0, ONE);
    send_pixel(24'd0, 1'b0);
    send_pixel(24'd1, 1'b0);
    send_pixel(24'd2, 1'b1);

    // Coordinates that leave the word range in both directions.
    configure(8191, 65535, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_pixel(24'd0, 1'b0);
    send_pixel(24'd8190, 1'b1);
    send_pixel(24'hFFFFFF, 1'b0);
    configure(8191, 65535, 0, 0, 32'h7FFF_FFFF);
    send_pixel(24'd8190, 1'b0);
    send_pixel(24'd0, 1'b1);

    configure(4096, 8, -2 * ONE, -ONE, ONE / 4);
    send_pixel(24'd0, 1'b0);
    send_pixel(24'(4096 * 4 + 8), 1'b0);
    send_pixel(24'(4096 * 3 + 5), 1'b1);

    // Random frames: mostly views over the interesting part of the plane.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      phase++;
      calm = (phase == 3);
      mode = $urandom_range(0, 9);
      if (mode == 7 || mode == 8) begin
        w    = $urandom_range(0, 8191);
        lim  = $urandom_range(0, 40);
        re   = $urandom;
        im   = $urandom;
        st   = $urandom;
        span = 24'hFFFFFF;
      end else begin
        case ($urandom_range(0, 7))
          0: w = 1;
          1: w = 4096;
          2: w = 8191;
          default: w = $urandom_range(2, 48);
        endcase
        lim = (mode == 9) ? $urandom_range(0, 2) : $urandom_range(1, 60);
        re  = -2 * ONE - int'($urandom_range(0, ONE / 4));
        im  = -(3 * ONE / 2) + int'($urandom_range(0, ONE / 4)) - ONE / 8;
        st  = (3 * ONE) / w;
        st  = st - st / 4 + int'($urandom_range(0, st / 2));
        if ($urandom_range(0, 9) == 0) st = -st;
        span = longint'(w) * ((w < 24) ? 24 : w) - 1;
        if (span > 24'hFFFFFF) span = 24'hFFFFFF;
      end
      configure(w, lim, re, im, st);
      count = $urandom_range(40, 90);
      for (k = 0; k < count && sent < RANDOM_ITEMS; k++) begin
        if ($urandom_range(0, 7) == 0) pix = INDEX_BITS'($urandom);
        else pix = INDEX_BITS'($urandom_range(0, int'(span)));
        last_flag = (k == count - 1) || ($urandom_range(0, 15) == 0);
        send_pixel(pix, last_flag);
        sent++;
      end
    end
    calm = 1'b0;

    drain();
    repeat (40) @(posedge clk_i);
    while (board.expected_q.size() != 0) begin
      r = board.expected_q.pop_front();
      board.report($sformatf("no result for request expecting count %0d", r.count));
    end
    if (board.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
